// ===== hw/rtl/gfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfq_pkg: shared types and constants of the grouped fifo queue
// Operation and status codes, the transaction structs and the fixed sizes.
// ----------------------------------------------------------------------------
package gfq_pkg;

  localparam int unsigned NUM_GROUPS  = 4;
  localparam int unsigned VALUE_WIDTH = 16;
  localparam int unsigned GROUP_DEPTH = 1024;

  localparam int unsigned GROUP_W = $clog2(NUM_GROUPS);

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_ENQ   = 2'd0,
    ST_DEQ   = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef struct packed {
    op_e                    operation;
    logic [GROUP_W-1:0]     group;
    logic [VALUE_WIDTH-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic [GROUP_W-1:0]     out_group;
    logic [VALUE_WIDTH-1:0] out_value;
  } rsp_t;

endpackage

// ===== hw/rtl/gfq_item_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gfq_item_ram: item storage of the grouped fifo queue
// Single port synchronous ram, one row per group, registered read data.
// ----------------------------------------------------------------------------
module gfq_item_ram #(
  parameter int unsigned GROUP_DEPTH = gfq_pkg::GROUP_DEPTH,
  localparam int unsigned PTR_W = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1
) (
  input  logic                            clk_i,
  input  logic                            en_i,
  input  logic                            we_i,
  input  logic [gfq_pkg::GROUP_W-1:0]     grp_i,
  input  logic [PTR_W-1:0]                addr_i,
  input  logic [gfq_pkg::VALUE_WIDTH-1:0] wdata_i,
  output logic [gfq_pkg::VALUE_WIDTH-1:0] rdata_o
);

  logic [gfq_pkg::VALUE_WIDTH-1:0] mem [gfq_pkg::NUM_GROUPS][GROUP_DEPTH];
  logic [gfq_pkg::VALUE_WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem[grp_i][addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem[grp_i][addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hw/rtl/grouped_fifo_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_fifo_queue: team queue with per-group fifos and a group order list
// Values wait in their group's fifo; groups are served in the order in which
// they became non-empty.
// ----------------------------------------------------------------------------
// The block takes one transaction per clock cycle: busy_o stays low, so a new
// command may be issued with start_i in every cycle. Each command yields
// exactly one result, shown for one cycle with done_o in the cycle right
// after the command was taken. The item ram, whose read data is registered,
// serves at most one enqueue write or dequeue read of each command. The
// receiver cannot stall, so results must be captured as they appear. A
// dequeued value comes straight from the ram read register.
module grouped_fifo_queue #(
  parameter int unsigned GROUP_DEPTH = gfq_pkg::GROUP_DEPTH
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start_i,
  input  gfq_pkg::req_t req_i,
  output logic          busy_o,
  output logic          done_o,
  output gfq_pkg::rsp_t result_o
);

  // pointer and fill level widths of one group fifo
  localparam int unsigned PTR_W = (GROUP_DEPTH > 1) ? $clog2(GROUP_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(GROUP_DEPTH + 1);
  // order list sizes
  localparam int unsigned OCNT_W = $clog2(gfq_pkg::NUM_GROUPS + 1);
  localparam int unsigned GW     = gfq_pkg::GROUP_W;

  // per-group fifo bookkeeping
  logic [PTR_W-1:0] grp_head_q [gfq_pkg::NUM_GROUPS];
  logic [PTR_W-1:0] grp_head_d [gfq_pkg::NUM_GROUPS];
  logic [CNT_W-1:0] grp_cnt_q  [gfq_pkg::NUM_GROUPS];
  logic [CNT_W-1:0] grp_cnt_d  [gfq_pkg::NUM_GROUPS];

  // order list of non-empty groups
  logic [GW-1:0]     slot_q [gfq_pkg::NUM_GROUPS];
  logic [GW-1:0]     slot_d [gfq_pkg::NUM_GROUPS];
  logic [GW-1:0]     ohead_q, ohead_d;
  logic [OCNT_W-1:0] ocnt_q, ocnt_d;

  // result registers
  logic             done_q, done_d;
  gfq_pkg::status_e status_q, status_d;
  logic [GW-1:0]    ogrp_q, ogrp_d;

  // working signals
  logic                            accept;
  logic                            is_deq;
  logic [GW-1:0]                   sel_grp;
  logic [PTR_W-1:0]                sel_head;
  logic [CNT_W-1:0]                sel_cnt;
  logic [CNT_W:0]                  pos_sum;
  logic [PTR_W-1:0]                tail_pos;
  logic [PTR_W-1:0]                head_next;
  logic [GW-1:0]                   otail;
  logic                            ram_en;
  logic                            ram_we;
  logic [PTR_W-1:0]                ram_addr;
  logic [gfq_pkg::VALUE_WIDTH-1:0] ram_rdata;

  assign accept = start_i && !busy_o;
  assign is_deq = (req_i.operation == gfq_pkg::OP_DEQ);

  // one fifo is touched per transaction: the enqueue group or the front group
  assign sel_grp  = is_deq ? slot_q[ohead_q] : req_i.group;
  assign sel_head = grp_head_q[sel_grp];
  assign sel_cnt  = grp_cnt_q[sel_grp];

  // write position is head plus fill level, wrapped once (sum < 2 * depth)
  assign pos_sum  = (CNT_W + 1)'(sel_head) + (CNT_W + 1)'(sel_cnt);
  assign tail_pos = (pos_sum >= (CNT_W + 1)'(GROUP_DEPTH))
                  ? PTR_W'(pos_sum - (CNT_W + 1)'(GROUP_DEPTH))
                  : PTR_W'(pos_sum);

  assign head_next = (sel_head == PTR_W'(GROUP_DEPTH - 1)) ? '0 : sel_head + 1'b1;

  // order list is a power-of-two ring, so the tail wraps naturally
  assign otail = ohead_q + GW'(ocnt_q);

  always_comb begin
    grp_head_d = grp_head_q;
    grp_cnt_d  = grp_cnt_q;
    slot_d     = slot_q;
    ohead_d    = ohead_q;
    ocnt_d     = ocnt_q;
    done_d     = accept;
    status_d   = status_q;
    ogrp_d     = '0;
    ram_en     = 1'b0;
    ram_we     = 1'b0;
    ram_addr   = tail_pos;

    if (accept) begin
      if (!is_deq) begin
        if (sel_cnt == CNT_W'(GROUP_DEPTH)) begin
          // full group: value dropped, nothing changes
          status_d = gfq_pkg::ST_FULL;
        end else begin
          status_d  = gfq_pkg::ST_ENQ;
          ram_en    = 1'b1;
          ram_we    = 1'b1;
          grp_cnt_d[sel_grp] = sel_cnt + 1'b1;
          // group becomes non-empty: join the back of the order list
          if (sel_cnt == '0) begin
            slot_d[otail] = sel_grp;
            ocnt_d        = ocnt_q + 1'b1;
          end
        end
      end else begin
        if (ocnt_q == '0) begin
          status_d = gfq_pkg::ST_EMPTY;
        end else begin
          status_d = gfq_pkg::ST_DEQ;
          ogrp_d   = sel_grp;
          ram_en   = 1'b1;
          ram_addr = sel_head;
          grp_head_d[sel_grp] = head_next;
          grp_cnt_d[sel_grp]  = sel_cnt - 1'b1;
          // last value of the front group: retire it from the order list
          if (sel_cnt == CNT_W'(1)) begin
            ohead_d = ohead_q + 1'b1;
            ocnt_d  = ocnt_q - 1'b1;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < gfq_pkg::NUM_GROUPS; i++) begin
        grp_head_q[i] <= '0;
        grp_cnt_q[i]  <= '0;
      end
      ohead_q  <= '0;
      ocnt_q   <= '0;
      done_q   <= 1'b0;
      status_q <= gfq_pkg::ST_ENQ;
      ogrp_q   <= '0;
    end else begin
      grp_head_q <= grp_head_d;
      grp_cnt_q  <= grp_cnt_d;
      ohead_q    <= ohead_d;
      ocnt_q     <= ocnt_d;
      done_q     <= done_d;
      status_q   <= status_d;
      ogrp_q     <= ogrp_d;
    end
  end

  // order list entries hold no reset; only live slots are ever read
  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  gfq_item_ram #(
    .GROUP_DEPTH(GROUP_DEPTH)
  ) u_item_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .grp_i  (sel_grp),
    .addr_i (ram_addr),
    .wdata_i(req_i.value),
    .rdata_o(ram_rdata)
  );

  // never stalls: a command is accepted whenever start_i is high
  assign busy_o = 1'b0;
  assign done_o = done_q;

  assign result_o.status    = status_q;
  assign result_o.out_group = ogrp_q;
  // value fields read zero unless an item was dequeued
  assign result_o.out_value = (status_q == gfq_pkg::ST_DEQ) ? ram_rdata : '0;

`ifndef ASSERT_OFF
  // every accepted transaction gives its result in the next cycle
  a_done_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> done_o)
    else $error("result strobe missing after accepted transaction");

  a_no_spurious_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> !done_o)
    else $error("result strobe without accepted transaction");

  // the front group of the order list always holds at least one value
  a_front_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ocnt_q != '0) |-> (grp_cnt_q[slot_q[ohead_q]] != '0))
    else $error("front group of order list is empty");

  // order list never holds more groups than exist
  a_order_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ocnt_q <= OCNT_W'(gfq_pkg::NUM_GROUPS))
    else $error("order list overflow");

  // empty status only when the order list was empty
  a_empty_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && is_deq && (ocnt_q != '0) |=> (result_o.status == gfq_pkg::ST_DEQ))
    else $error("dequeue on non-empty queue did not return an item");
`endif

endmodule

// ===== tb/sv/grouped_fifo_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grouped_fifo_queue_tb: self-checking bench for the grouped fifo queue
// Walks a directed command table, then random enqueue/dequeue traffic and a
// fill-to-full pass, predicting every result with a behavioral team queue.
// ----------------------------------------------------------------------------
module grouped_fifo_queue_tb;
  import gfq_pkg::*;

  // watchdog: cycles with no transaction and no result before giving up
  localparam int unsigned STALL_LIMIT = 500;
  // cycles to wait after the last result has come back
  localparam int unsigned TAIL_CYCLES = 4;
  localparam int unsigned RAND_ITEMS  = 400;
  localparam int unsigned PHASE_LEN   = 100;
  // enqueues tried on the full group, and dequeues after the fill pass
  localparam int unsigned FULL_TRIES  = 4;
  localparam int unsigned DRAIN_ITEMS = 64;

  // one row of the directed table; st_known marks an expectation typed in
  typedef struct packed {
    op_e                    op;
    logic [GROUP_W-1:0]     grp;
    logic [VALUE_WIDTH-1:0] val;
    logic                   st_known;
    status_e                st;
  } dir_row_t;

  localparam int unsigned DIR_ROWS_N = 23;
  localparam dir_row_t DIR_ROWS [0:DIR_ROWS_N-1] = '{
    '{OP_DEQ, 2'd3, 16'hFFFF, 1'b1, ST_EMPTY}, // dequeue right after reset
    '{OP_ENQ, 2'd0, 16'h0000, 1'b1, ST_ENQ},   // lowest group, lowest value
    '{OP_ENQ, 2'd3, 16'hFFFF, 1'b1, ST_ENQ},   // highest group, highest value
    '{OP_ENQ, 2'd0, 16'h1234, 1'b1, ST_ENQ},   // group 0 already listed
    '{OP_ENQ, 2'd1, 16'hAAAA, 1'b1, ST_ENQ},
    '{OP_ENQ, 2'd3, 16'h5555, 1'b1, ST_ENQ},
    '{OP_DEQ, 2'd2, 16'hBEEF, 1'b0, ST_DEQ},   // group/value ignored on dequeue
    '{OP_DEQ, 2'd0, 16'h0000, 1'b0, ST_DEQ},   // group 0 runs dry and retires
    '{OP_DEQ, 2'd1, 16'h0F0F, 1'b0, ST_DEQ},
    '{OP_ENQ, 2'd0, 16'h8001, 1'b1, ST_ENQ},   // group 0 rejoins at the back
    '{OP_DEQ, 2'd3, 16'hFFFF, 1'b0, ST_DEQ},
    '{OP_DEQ, 2'd0, 16'h0000, 1'b0, ST_DEQ},
    '{OP_DEQ, 2'd0, 16'h0000, 1'b0, ST_DEQ},
    '{OP_DEQ, 2'd2, 16'h7777, 1'b1, ST_EMPTY}, // drained again
    '{OP_ENQ, 2'd2, 16'h7FFF, 1'b1, ST_ENQ},
    '{OP_ENQ, 2'd2, 16'h0001, 1'b1, ST_ENQ},
    '{OP_DEQ, 2'd0, 16'h0000, 1'b0, ST_DEQ},
    '{OP_ENQ, 2'd1, 16'h00FF, 1'b1, ST_ENQ},   // queued behind group 2
    '{OP_ENQ, 2'd2, 16'hFF00, 1'b1, ST_ENQ},   // group 2 still listed
    '{OP_DEQ, 2'd3, 16'h0000, 1'b0, ST_DEQ},
    '{OP_DEQ, 2'd3, 16'h0000, 1'b0, ST_DEQ},
    '{OP_DEQ, 2'd3, 16'h0000, 1'b0, ST_DEQ},
    '{OP_DEQ, 2'd1, 16'hFFFF, 1'b1, ST_EMPTY}
  };

  logic  clk_i;
  logic  rst_ni;
  logic  start_i;
  req_t  req_i;
  logic  busy_o;
  logic  done_o;
  rsp_t  result_o;

  grouped_fifo_queue DUT (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start_i),
    .req_i    (req_i),
    .busy_o   (busy_o),
    .done_o   (done_o),
    .result_o (result_o)
  );

  // behavioral team queue: per-group circular fifos plus the service order
  logic [VALUE_WIDTH-1:0] grp_mem  [NUM_GROUPS][GROUP_DEPTH];
  int unsigned            grp_rd   [NUM_GROUPS];
  int unsigned            grp_fill [NUM_GROUPS];
  int unsigned            serve_order [$];

  rsp_t        pending_results [$];  // expected results, oldest first
  int unsigned fail_count  = 0;
  int unsigned idle_cycles = 0;
  bit          sender_idles = 1'b0;

  // typed-in expectation for the transaction currently on the inputs
  bit   typed_valid = 1'b0;
  rsp_t typed_rsp;

  initial clk_i = 1'b0;
  always #2 clk_i = ~clk_i;

  // applies one command to the behavioral queue, returns its result
  function automatic rsp_t predict_queue_op(req_t r);
    rsp_t        res;
    int unsigned g;
    int unsigned slot;
    res = '{status: ST_ENQ, out_group: '0, out_value: '0};
    if (r.operation == OP_ENQ) begin
      g = r.group % NUM_GROUPS;
      if (grp_fill[g] >= GROUP_DEPTH) begin
        res.status = ST_FULL;  // dropped, nothing changes
      end else begin
        slot = (grp_rd[g] + grp_fill[g]) % GROUP_DEPTH;
        grp_mem[g][slot] = r.value;
        // a group joins the service order when it turns non-empty
        if (grp_fill[g] == 0) serve_order.push_back(g);
        grp_fill[g]++;
      end
    end else if (serve_order.size() == 0) begin
      res.status = ST_EMPTY;
    end else begin
      g = serve_order[0];
      res.status    = ST_DEQ;
      res.out_group = GROUP_W'(g);
      res.out_value = grp_mem[g][grp_rd[g]];
      grp_rd[g]     = (grp_rd[g] + 1) % GROUP_DEPTH;
      grp_fill[g]--;
      // front group retires once its fifo runs dry
      if (grp_fill[g] == 0) void'(serve_order.pop_front());
    end
    return res;
  endfunction

  // monitor: predicts on every accepted transaction, checks every result
  always @(posedge clk_i) begin : monitor
    rsp_t predicted;
    rsp_t want;
    bit   activity;
    activity = 1'b0;
    if (rst_ni) begin
      // push first, so a result shown in the same cycle as its command would still find its entry
      if (start_i && !busy_o) begin
        predicted = predict_queue_op(req_i);
        pending_results.push_back(typed_valid ? typed_rsp : predicted);
        activity = 1'b1;
      end
      if (done_o) begin
        activity = 1'b1;
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d group %0d value %h",
                 result_o.status, result_o.out_group, result_o.out_value);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          if (result_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, result_o.status);
            fail_count++;
          end
          if (result_o.out_group !== want.out_group) begin
            $error("out_group: expected %0d, got %0d", want.out_group,
                   result_o.out_group);
            fail_count++;
          end
          if (result_o.out_value !== want.out_value) begin
            $error("out_value: expected %h, got %h", want.out_value,
                   result_o.out_value);
            fail_count++;
          end
        end
      end
      // watchdog over stretches with nothing moving in either direction
      idle_cycles = activity ? 0 : idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // issues one command; entered and left at a falling edge, start stays high
  task automatic issue(input req_t r, input bit known, input status_e st);
    int unsigned gap;
    gap = sender_idles ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      start_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    typed_valid = known;
    typed_rsp   = '{status: st, out_group: '0, out_value: '0};
    start_i <= 1'b1;
    req_i   <= r;
    do @(posedge clk_i); while (busy_o);
    @(negedge clk_i);
  endtask

  // holds the sender off until every outstanding result has come back
  task automatic wait_drained();
    start_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  initial begin : stimulus
    req_t        r;
    int unsigned enq_pct;
    int unsigned g;
    rst_ni  = 1'b0;
    start_i = 1'b0;
    req_i   = '{operation: OP_ENQ, group: '0, value: '0};
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // directed table: ordering, retiring and rejoining of groups
    sender_idles = 1'b1;
    foreach (DIR_ROWS[i]) begin
      r = '{operation: DIR_ROWS[i].op, group: DIR_ROWS[i].grp, value: DIR_ROWS[i].val};
      issue(r, DIR_ROWS[i].st_known, DIR_ROWS[i].st);
    end

    // random traffic in phases of varying enqueue bias and idling
    for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
      if (n % PHASE_LEN == 0) begin
        case ($urandom_range(0, 2))
          0:       enq_pct = 35;
          1:       enq_pct = 50;
          default: enq_pct = 70;
        endcase
        sender_idles = ($urandom_range(0, 2) != 0);
      end
      // pressure point: pause until the queue has answered everything
      if (n == RAND_ITEMS / 2) wait_drained();
      r.operation = ($urandom_range(0, 99) < enq_pct) ? OP_ENQ : OP_DEQ;
      r.group     = GROUP_W'($urandom_range(0, NUM_GROUPS - 1));
      r.value     = VALUE_WIDTH'($urandom);
      issue(r, 1'b0, ST_ENQ);
    end

    // fill one group to the brim, its head now sits at a random position
    sender_idles = 1'b0;
    g = $urandom_range(0, NUM_GROUPS - 1);
    while (grp_fill[g] < GROUP_DEPTH) begin
      r = '{operation: OP_ENQ, group: GROUP_W'(g), value: VALUE_WIDTH'($urandom)};
      issue(r, 1'b0, ST_ENQ);
    end
    // enqueue into a full group is dropped
    for (int unsigned k = 0; k < FULL_TRIES; k++) begin
      r = '{operation: OP_ENQ, group: GROUP_W'(g), value: VALUE_WIDTH'($urandom)};
      issue(r, 1'b1, ST_FULL);
    end
    // take some values out of the queue again, with idling
    sender_idles = 1'b1;
    for (int unsigned k = 0; k < DRAIN_ITEMS; k++) begin
      r = '{operation: OP_DEQ, group: GROUP_W'($urandom), value: VALUE_WIDTH'($urandom)};
      issue(r, 1'b0, ST_DEQ);
    end

    // let the last results come back
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
